### sv/mexp_pkg.sv
// Shared width, types and control structs for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t result;
  } mul_resp_t;

endpackage
`default_nettype wire

### sv/modular_exponentiation_unit.sv
// Top level: base^exponent mod modulus by right-to-left square and multiply.
//
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = modulus, 1 = exponent); both reset to 1. Write only while idle.
// Input: one beat on s_* carries one base. s_tready is high while the
// sequencer is idle, also while a finished residue still waits on m_*.
// Output: one beat on m_* carries the residue; m_tdata holds while
// m_tvalid is high and m_tready is low, and the sequencer waits for the
// output register before finishing the next item.
// Sequence: the base is first reduced mod n (RED), then each exponent bit
// up to the highest one takes a STEP, plus one multiply (MULP) if it is
// set and one squaring (MULS) unless it is the last, each in the shared
// bit-serial multiplier, and FIN loads the output. An exponent of zero or
// a modulus of zero goes from the input beat straight to FIN.
// One item is in work at a time.
// Reset: synchronous, clears the sequencer and the output valid and sets
// both configuration registers to 1.
`default_nettype none
module modular_exponentiation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] base_value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [31:0] residue
);

  localparam logic CFG_MODULUS  = 1'b0;
  localparam logic CFG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    IDLE,
    RED,
    STEP,
    MULP,
    MULS,
    FIN
  } state_t;

  state_t              state;
  logic [31:0]         modulus;
  logic [31:0]         exponent;
  mexp_pkg::word_t     n;
  mexp_pkg::word_t     e;
  mexp_pkg::word_t     power;
  mexp_pkg::word_t     prod;
  logic [31:0]         res;
  mexp_pkg::mul_req_t  req;
  mexp_pkg::mul_resp_t resp;
  mexp_pkg::word_t     e_shift;
  mexp_pkg::word_t     in_n;
  mexp_pkg::word_t     in_e;
  logic                start_next;

  assign e_shift  = e >> 1;
  assign in_n     = mexp_pkg::word_t'(modulus);
  assign in_e     = mexp_pkg::word_t'(exponent);
  assign s_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= 32'd1;
      exponent <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS:  modulus  <= cfg_data;
        CFG_EXPONENT: exponent <= cfg_data;
        default:      ;
      endcase
    end
  end

  mexp_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .n    (n),
    .req  (req),
    .resp (resp)
  );

  always_comb begin
    case (state)
      IDLE:    start_next = s_tvalid && (in_e != '0) && (in_n != '0);
      STEP:    start_next = e[0] || (e_shift != '0);
      MULP:    start_next = resp.done && (e_shift != '0);
      default: start_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      m_tvalid  <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= start_next;
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            n <= in_n;
            e <= in_e;
            if (in_e == '0) begin
              res   <= 32'd1;
              state <= FIN;
            end else if (in_n == '0) begin
              res   <= 32'd0;
              state <= FIN;
            end else begin
              req.x     <= (in_n == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
              req.y     <= mexp_pkg::word_t'(s_tdata);
              state     <= RED;
            end
          end
        end
        RED: begin
          if (resp.done) begin
            power <= resp.result;
            prod  <= (n == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);
            state <= STEP;
          end
        end
        STEP: begin
          if (e[0]) begin
            req.x     <= prod;
            req.y     <= power;
            state     <= MULP;
          end else begin
            e <= e_shift;
            if (e_shift != '0) begin
              req.x     <= power;
              req.y     <= power;
              state     <= MULS;
            end else begin
              res   <= 32'(prod);
              state <= FIN;
            end
          end
        end
        MULP: begin
          if (resp.done) begin
            prod <= resp.result;
            e    <= e_shift;
            if (e_shift != '0) begin
              req.x     <= power;
              req.y     <= power;
              state     <= MULS;
            end else begin
              res   <= 32'(resp.result);
              state <= FIN;
            end
          end
        end
        MULS: begin
          if (resp.done) begin
            power <= resp.result;
            state <= STEP;
          end
        end
        FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res;
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_mul_free: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !resp.busy)
    else $error("multiplier busy while sequencer idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !resp.busy)
    else $error("multiply started while multiplier busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    resp.done |-> (state == RED || state == MULP || state == MULS))
    else $error("multiply finished outside a wait state");
`endif

endmodule
`default_nettype wire

### sv/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none
module mexp_mulmod (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mexp_pkg::word_t     n,
  input  wire mexp_pkg::mul_req_t  req,
  output mexp_pkg::mul_resp_t      resp
);

  // (a + b) mod n for a, b < n
  function automatic mexp_pkg::word_t add_mod(input mexp_pkg::word_t a,
                                              input mexp_pkg::word_t b,
                                              input mexp_pkg::word_t m);
    logic [mexp_pkg::WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return mexp_pkg::word_t'(s);
  endfunction

  mexp_pkg::word_t            acc;
  mexp_pkg::word_t            acc_next;
  mexp_pkg::word_t            x;
  mexp_pkg::word_t            y;
  logic [mexp_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;

  always_comb begin
    acc_next = add_mod(acc, acc, n);
    if (y[mexp_pkg::WIDTH-1]) begin
      acc_next = add_mod(acc_next, x, n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      acc <= acc_next;
      y   <= y << 1;
      cnt <= cnt + mexp_pkg::CNT_W'(1);
      if (cnt == mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc  <= '0;
        x    <= req.x;
        y    <= req.y;
        cnt  <= '0;
        busy <= 1'b1;
      end
    end
  end

  assign resp.busy   = busy;
  assign resp.done   = done;
  assign resp.result = acc;

endmodule
`default_nettype wire

### test/tb_modular_exponentiation_unit.sv
// Self-checking testbench for modular_exponentiation_unit: directed table plus random phases.
`default_nettype none
module tb_modular_exponentiation_unit;

  typedef logic [31:0] word_t;

  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  localparam word_t WORD_MAX    = 32'hFFFF_FFFF;
  localparam word_t PRIME_MAX   = 32'hFFFF_FFFB;
  localparam int RANDOM_ITEMS   = 264;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 6000;
  localparam int LATENCY_MAX    = 2 * mexp_pkg::WIDTH * (mexp_pkg::WIDTH + 2) + 64;
  localparam int CYCLE_LIMIT    = 3_000_000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    word_t n;
    word_t e;
    word_t b;
    word_t want;
    logic  known;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  // known = 1: residue typed in; otherwise taken from the predictor
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{32'd1,      32'd1,         32'd5,          32'd0,          1'b1},
    '{32'd1,      32'd1,         32'd0,          32'd0,          1'b1},
    '{WORD_MAX,   32'd0,         WORD_MAX,       32'd1,          1'b1},
    '{32'd1,      32'd0,         32'd7,          32'd1,          1'b1},
    '{32'd0,      32'd5,         32'd3,          32'd0,          1'b1},
    '{32'd0,      32'd0,         32'd3,          32'd1,          1'b1},
    '{WORD_MAX,   32'd1,         WORD_MAX,       32'd0,          1'b1},
    '{WORD_MAX,   32'd1,         32'hFFFF_FFFE,  32'hFFFF_FFFE,  1'b1},
    '{32'd13,     32'd1,         32'd100,        32'd9,          1'b1},
    '{WORD_MAX,   WORD_MAX,      32'd0,          32'd0,          1'b1},
    '{WORD_MAX,   WORD_MAX,      32'd1,          32'd1,          1'b1},
    '{WORD_MAX,   WORD_MAX,      32'hFFFF_FFFE,  32'd0,          1'b0},
    '{PRIME_MAX,  32'hFFFF_FFFA, 32'd2,          32'd0,          1'b0},
    '{32'h8000_0000, 32'd31,     32'd2,          32'd0,          1'b0},
    '{WORD_MAX,   32'd2,         32'h1234_5678,  32'd0,          1'b0},
    '{32'd2,      WORD_MAX,      WORD_MAX,       32'd0,          1'b0},
    '{32'd1000,   32'd3,         32'd0,          32'd0,          1'b1},
    '{WORD_MAX,   32'h8000_0000, 32'd3,          32'd0,          1'b0}
  };

  logic  clk;
  logic  rst;
  logic  cfg_we;
  logic  cfg_index;
  logic  [31:0] cfg_data;
  logic  s_tvalid;
  logic  s_tready;
  logic  [31:0] s_tdata;   // [31:0] base_value
  logic  m_tvalid;
  logic  m_tready;
  logic  [31:0] m_tdata;   // [31:0] residue

  word_t residue_q [$];
  word_t want_res;
  int    err_count;
  int    cycle_count;
  int    burst_left;
  bit    hold_req;

  modular_exponentiation_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t modexp_predict(word_t n, word_t e, word_t b);
    logic [63:0] prod;
    logic [63:0] pw;
    logic [63:0] nn;
    word_t       ee;
    if (e == '0) return word_t'(1);
    if (n == '0) return '0;
    nn = {32'd0, n};
    ee = e;
    prod = 64'd1 % nn;
    pw = {32'd0, b} % nn;
    while (ee != '0) begin
      if (ee[0]) prod = (prod * pw) % nn;
      ee = ee >> 1;
      if (ee != '0) pw = (pw * pw) % nn;
    end
    return prod[31:0];
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return word_t'(1);
      2: return WORD_MAX;
      3: return PRIME_MAX;
      4: return word_t'(1) << $urandom_range(0, 31);
      5: return word_t'($urandom_range(2, 255));
      6: return $urandom | 32'h8000_0001;
      default: return $urandom;
    endcase
  endfunction

  // mostly short exponents; full-width ones take longest per beat
  function automatic word_t pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WORD_MAX;
      2: return $urandom;
      3: return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom & ((word_t'(1) << $urandom_range(1, 12)) - 1);
    endcase
  endfunction

  function automatic word_t pick_base(word_t n);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return word_t'(1);
      2: return WORD_MAX;
      3: return n - 1;
      4: return n;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_base(word_t b, word_t want);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= $urandom;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    residue_q.push_back(want);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (residue_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(word_t n, word_t e);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data  <= n;
    @(negedge clk);
    cfg_index <= REG_EXPONENT;
    cfg_data  <= e;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: segments of differing stall patterns, one long hold-off
  initial begin
    rx_mode_t mode;
    int seg;
    int period;
    int tick;
    int hold_left;
    bit held;
    m_tready = 1'b0;
    tick = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      seg = $urandom_range(20, 400);
      mode = rx_mode_t'($urandom_range(0, 3));
      period = $urandom_range(2, 9);
      repeat (seg) begin
        @(negedge clk);
        if (!held && hold_req) begin
          held = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          m_tready <= 1'b0;
        end else begin
          case (mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (tick % period) != 0;
            default:     m_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
        tick++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (residue_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected residue beat: %h", m_tdata);
      end else begin
        want_res = residue_q.pop_front();
        if (m_tdata !== want_res) begin
          err_count++;
          if (err_count <= 10)
            $display("residue mismatch: expected %h, got %h", want_res, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    word_t cur_n;
    word_t cur_e;
    word_t b;
    int sent;
    int cnt;
    hold_req = 1'b0;
    burst_left = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODULUS;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_n = word_t'(1);
    cur_e = word_t'(1);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].n != cur_n || dir_tab[i].e != cur_e) begin
        cur_n = dir_tab[i].n;
        cur_e = dir_tab[i].e;
        write_config(cur_n, cur_e);
      end
      send_base(dir_tab[i].b, dir_tab[i].known ? dir_tab[i].want
                                               : modexp_predict(cur_n, cur_e, dir_tab[i].b));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cur_n = pick_modulus();
      cur_e = pick_exponent();
      write_config(cur_n, cur_e);
      cnt = $urandom_range(6, 18);
      // long group so the sender keeps offering through the hold-off
      if (!hold_req && sent >= HOLD_AFTER) begin
        cnt = 18;
        hold_req = 1'b1;
      end
      repeat (cnt) begin
        b = pick_base(cur_n);
        send_base(b, modexp_predict(cur_n, cur_e, b));
        sent++;
      end
    end

    drain();
    repeat (LATENCY_MAX) @(negedge clk);
    if (err_count + residue_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation_unit.sv
test/tb_modular_exponentiation_unit.sv
